// File: rtl/core/lmfb_pkg.sv
// Shared types and constants for the LED matrix frame buffer scanner.
package lmfb_pkg;

	// Command kinds as they arrive on the command channel
	localparam logic [1:0] KIND_CLEAR  = 2'd0;
	localparam logic [1:0] KIND_POINT  = 2'd1;
	localparam logic [1:0] KIND_FILL   = 2'd2;
	localparam logic [1:0] KIND_RENDER = 2'd3;

	// Configuration register indexes (paddr bit 2)
	localparam logic REG_ACROSS = 1'b0;
	localparam logic REG_DOWN   = 1'b1;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// Signed width for corner and far-edge sums (8-bit position plus 7-bit extent)
	localparam int SUM_W = 10;

	// Job queue depth between front and back
	localparam int QDEPTH = 2;

	// Digit register for the first pixel row of a tile; later rows count down from it
	localparam logic [3:0] ROW_REG_TOP = 4'd8;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_FILL,
		OP_RENDER
	} op_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_FILL_RD,
		BK_FILL_WR,
		BK_REN_RD,
		BK_REN_OUT
	} back_state_t;

endpackage

// File: rtl/core/lmfb_if.sv
// Channel interfaces: command input, job queue link and render word output.
interface lmfb_cmd_if;
	logic              valid;
	logic              ready;
	logic        [1:0] kind;
	logic signed [7:0] pos_x;
	logic signed [7:0] pos_y;
	logic        [6:0] rect_width;
	logic        [6:0] rect_height;
	logic              pixel_on;

	modport source (output valid, kind, pos_x, pos_y, rect_width, rect_height, pixel_on,
		input ready);
	modport sink (input valid, kind, pos_x, pos_y, rect_width, rect_height, pixel_on,
		output ready);
endinterface

interface lmfb_job_if #(
	parameter int CW = 5,
	parameter int RW = 4
);
	logic               valid;
	logic               ready;
	lmfb_pkg::op_t      op;
	logic               on;
	logic [CW-1:0]      col0;
	logic [CW-1:0]      col1;
	logic [RW-1:0]      row0;
	logic [RW-1:0]      row1;

	modport source (output valid, op, on, col0, col1, row0, row1, input ready);
	modport sink (input valid, op, on, col0, col1, row0, row1, output ready);
endinterface

interface lmfb_word_if;
	logic       valid;
	logic       ready;
	logic [3:0] row_register;
	logic [7:0] row_data;
	logic       frame_end;
	logic       last;

	modport source (output valid, row_register, row_data, frame_end, last, input ready);
	modport sink (input valid, row_register, row_data, frame_end, last, output ready);
endinterface

// File: rtl/core/lmfb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lmfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/lmfb_front.sv
// Command front end: classifies commands and clips rectangles to the grid.
module lmfb_front #(
	parameter int MAX_A = 4,
	parameter int MAX_D = 2
) (
	input  logic [$clog2(MAX_A+1)-1:0] a_eff,
	input  logic [$clog2(MAX_D+1)-1:0] d_eff,
	lmfb_cmd_if.sink                   cmd,
	lmfb_job_if.source                 job
);

	localparam int AW = lmfb_pkg::SUM_W;
	localparam int CW = $clog2(8*MAX_A);
	localparam int RW = $clog2(8*MAX_D);

	logic signed [AW-1:0] xmax, ymax;
	logic signed [AW-1:0] xs, ys, w, h;
	logic signed [AW-1:0] x0, x1, y0, y1, x1c, y1c;
	logic                 empty;
	logic                 keep;

	// Grid extent in pixels
	assign xmax = signed'(AW'(a_eff) << 3);
	assign ymax = signed'(AW'(d_eff) << 3);

	// Extents: a point is a one by one rectangle
	always_comb begin
		xs = AW'(cmd.pos_x);
		ys = AW'(cmd.pos_y);
		if (cmd.kind == lmfb_pkg::KIND_POINT) begin
			w = 10'sd1;
			h = 10'sd1;
		end else begin
			w = signed'(AW'(cmd.rect_width));
			h = signed'(AW'(cmd.rect_height));
		end
	end

	// Clip to the grid, 1-based
	always_comb begin
		x0    = (xs < 10'sd1) ? 10'sd1 : xs;
		y0    = (ys < 10'sd1) ? 10'sd1 : ys;
		x1    = xs + w - 10'sd1;
		y1    = ys + h - 10'sd1;
		x1c   = (x1 > xmax) ? xmax : x1;
		y1c   = (y1 > ymax) ? ymax : y1;
		empty = (x0 > x1c) || (y0 > y1c);
	end

	// Classify: drop empty draws, forward everything else
	always_comb begin
		job.op = lmfb_pkg::OP_CLEAR;
		keep   = 1'b1;
		case (cmd.kind)
			lmfb_pkg::KIND_CLEAR: begin
				job.op = lmfb_pkg::OP_CLEAR;
			end
			lmfb_pkg::KIND_POINT, lmfb_pkg::KIND_FILL: begin
				job.op = lmfb_pkg::OP_FILL;
				keep   = !empty;
			end
			lmfb_pkg::KIND_RENDER: begin
				job.op = lmfb_pkg::OP_RENDER;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign job.on    = cmd.pixel_on;
	assign job.col0  = CW'(x0 - 10'sd1);
	assign job.col1  = CW'(x1c - 10'sd1);
	assign job.row0  = RW'(y0 - 10'sd1);
	assign job.row1  = RW'(y1c - 10'sd1);
	assign job.valid = cmd.valid && keep;
	assign cmd.ready = job.ready;

endmodule

// File: rtl/core/lmfb_queue.sv
// Short job queue between the front end and the store engine.
module lmfb_queue #(
	parameter int CW = 5,
	parameter int RW = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	lmfb_job_if.sink   in_job,
	lmfb_job_if.source out_job
);

	localparam int QD  = lmfb_pkg::QDEPTH;
	localparam int QPW = $clog2(QD);
	localparam int QCW = $clog2(QD+1);

	lmfb_pkg::op_t   op_q   [QD];
	logic            on_q   [QD];
	logic [CW-1:0]   col0_q [QD];
	logic [CW-1:0]   col1_q [QD];
	logic [RW-1:0]   row0_q [QD];
	logic [RW-1:0]   row1_q [QD];

	logic [QPW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCW-1:0]  count_q;
	logic            push, pop;

	assign in_job.ready  = (count_q != QCW'(QD));
	assign out_job.valid = (count_q != '0);
	assign push          = in_job.valid && in_job.ready;
	assign pop           = out_job.valid && out_job.ready;

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			op_q[wr_ptr_q]   <= in_job.op;
			on_q[wr_ptr_q]   <= in_job.on;
			col0_q[wr_ptr_q] <= in_job.col0;
			col1_q[wr_ptr_q] <= in_job.col1;
			row0_q[wr_ptr_q] <= in_job.row0;
			row1_q[wr_ptr_q] <= in_job.row1;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

	assign out_job.op   = op_q[rd_ptr_q];
	assign out_job.on   = on_q[rd_ptr_q];
	assign out_job.col0 = col0_q[rd_ptr_q];
	assign out_job.col1 = col1_q[rd_ptr_q];
	assign out_job.row0 = row0_q[rd_ptr_q];
	assign out_job.row1 = row1_q[rd_ptr_q];

endmodule

// File: rtl/core/lmfb_back.sv
// Store engine: clears, read-modify-write fills and render scan of the frame store.
module lmfb_back #(
	parameter int MAX_A = 4,
	parameter int MAX_D = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [$clog2(MAX_A+1)-1:0] a_eff,
	input  logic [$clog2(MAX_D+1)-1:0] d_eff,
	lmfb_job_if.sink                   job,
	lmfb_word_if.source                word
);

	localparam int CW    = $clog2(8*MAX_A);
	localparam int RW    = $clog2(8*MAX_D);
	localparam int BW    = (CW > 3) ? CW - 3 : 1;
	localparam int TRW   = (RW > 3) ? RW - 3 : 1;
	localparam int AAW   = $clog2(MAX_A+1);
	localparam int DDW   = $clog2(MAX_D+1);
	localparam int DEPTH = 8 * MAX_A * MAX_D;
	localparam int ADW   = $clog2(DEPTH);
	localparam int PW    = AAW + RW + 1;

	lmfb_pkg::back_state_t state_q, state_d;

	// Job registers and walk counters
	logic            on_q;
	logic [CW-1:0]   col0_q, col1_q;
	logic [RW-1:0]   row1_q;
	logic [RW-1:0]   row_q;
	logic [BW-1:0]   bc_q;
	logic [TRW-1:0]  tr_q;
	logic [2:0]      r_q;

	// Frame store side
	logic [DEPTH-1:0] valid_q;
	logic             rd_valid_q;
	logic [7:0]       rdata;
	logic [7:0]       old_byte, new_byte, mask;
	logic [ADW-1:0]   addr;
	logic [RW-1:0]    prow;
	logic [BW-1:0]    pcol;

	// Control decoded from state
	logic re, we, use_next, load, clear_all, start_fill, start_ren;
	logic can_load, fill_done, ren_final;
	logic [BW-1:0]  bc0, bc1, tc_n;
	logic [TRW-1:0] tr_n;
	logic [2:0]     r_n, lo, hi;

	// Output register
	logic       out_valid_q;
	logic [3:0] row_register_q;
	logic [7:0] row_data_q;
	logic       frame_end_q, last_q;

	assign bc0       = BW'(col0_q >> 3);
	assign bc1       = BW'(col1_q >> 3);
	assign fill_done = (bc_q == bc1) && (row_q == row1_q);
	assign ren_final = (r_q == 3'd7) && (bc_q == '0) && (tr_q == '0);
	assign can_load  = !out_valid_q || word.ready;

	// Next scan position: tiles count down, rows count up
	always_comb begin
		tc_n = bc_q;
		tr_n = tr_q;
		r_n  = r_q;
		if (bc_q != '0) begin
			tc_n = bc_q - BW'(1);
		end else begin
			tc_n = BW'(a_eff - AAW'(1));
			if (tr_q != '0) begin
				tr_n = tr_q - TRW'(1);
			end else begin
				tr_n = TRW'(d_eff - DDW'(1));
				r_n  = r_q + 3'd1;
			end
		end
	end

	// Next state and strobes
	always_comb begin
		state_d    = state_q;
		re         = 1'b0;
		we         = 1'b0;
		use_next   = 1'b0;
		load       = 1'b0;
		clear_all  = 1'b0;
		start_fill = 1'b0;
		start_ren  = 1'b0;
		job.ready  = 1'b0;
		case (state_q)
			lmfb_pkg::BK_IDLE: begin
				job.ready = 1'b1;
				if (job.valid) begin
					case (job.op)
						lmfb_pkg::OP_CLEAR: begin
							clear_all = 1'b1;
						end
						lmfb_pkg::OP_FILL: begin
							start_fill = 1'b1;
							state_d    = lmfb_pkg::BK_FILL_RD;
						end
						lmfb_pkg::OP_RENDER: begin
							start_ren = 1'b1;
							state_d   = lmfb_pkg::BK_REN_RD;
						end
						default: begin
							state_d = lmfb_pkg::BK_IDLE;
						end
					endcase
				end
			end
			lmfb_pkg::BK_FILL_RD: begin
				re      = 1'b1;
				state_d = lmfb_pkg::BK_FILL_WR;
			end
			lmfb_pkg::BK_FILL_WR: begin
				we      = 1'b1;
				state_d = fill_done ? lmfb_pkg::BK_IDLE : lmfb_pkg::BK_FILL_RD;
			end
			lmfb_pkg::BK_REN_RD: begin
				re      = 1'b1;
				state_d = lmfb_pkg::BK_REN_OUT;
			end
			lmfb_pkg::BK_REN_OUT: begin
				if (can_load) begin
					load = 1'b1;
					if (ren_final) begin
						state_d = lmfb_pkg::BK_IDLE;
					end else begin
						re       = 1'b1;
						use_next = 1'b1;
					end
				end
			end
			default: begin
				state_d = lmfb_pkg::BK_IDLE;
			end
		endcase
	end

	// Store address: tiles_across bytes per pixel row
	always_comb begin
		if (state_q == lmfb_pkg::BK_FILL_RD || state_q == lmfb_pkg::BK_FILL_WR) begin
			prow = row_q;
			pcol = bc_q;
		end else if (use_next) begin
			prow = RW'({tr_n, r_n});
			pcol = tc_n;
		end else begin
			prow = RW'({tr_q, r_q});
			pcol = bc_q;
		end
		addr = ADW'(PW'(a_eff) * PW'(prow) + PW'(pcol));
	end

	// Bit mask of the clipped span within the current byte
	always_comb begin
		lo = (bc_q == bc0) ? col0_q[2:0] : 3'd0;
		hi = (bc_q == bc1) ? col1_q[2:0] : 3'd7;
		for (int k = 0; k < 8; k++) begin
			mask[k] = (3'(k) >= lo) && (3'(k) <= hi);
		end
		old_byte = rd_valid_q ? rdata : 8'h00;
		new_byte = on_q ? (old_byte | mask) : (old_byte & ~mask);
	end

	lmfb_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (addr),
		.wdata (new_byte),
		.re    (re),
		.raddr (addr),
		.rdata (rdata)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lmfb_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Entry valid bits: unwritten bytes read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (clear_all) begin
				valid_q <= '0;
			end else if (we) begin
				valid_q[addr] <= 1'b1;
			end
			if (re) begin
				rd_valid_q <= valid_q[addr];
			end
		end
	end

	// Latch job and advance walk counters
	always_ff @(posedge clk) begin
		if (start_fill) begin
			on_q   <= job.on;
			col0_q <= job.col0;
			col1_q <= job.col1;
			row1_q <= job.row1;
			row_q  <= job.row0;
			bc_q   <= BW'(job.col0 >> 3);
		end else if (start_ren) begin
			bc_q <= BW'(a_eff - AAW'(1));
			tr_q <= TRW'(d_eff - DDW'(1));
			r_q  <= 3'd0;
		end else if (we) begin
			if (bc_q == bc1) begin
				bc_q  <= bc0;
				row_q <= row_q + RW'(1);
			end else begin
				bc_q <= bc_q + BW'(1);
			end
		end else if (use_next) begin
			bc_q <= tc_n;
			tr_q <= tr_n;
			r_q  <= r_n;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (word.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			row_register_q <= lmfb_pkg::ROW_REG_TOP - {1'b0, r_q};
			row_data_q     <= rd_valid_q ? rdata : 8'h00;
			frame_end_q    <= (bc_q == '0) && (tr_q == '0);
			last_q         <= ren_final;
		end
	end

	assign word.valid        = out_valid_q;
	assign word.row_register = row_register_q;
	assign word.row_data     = row_data_q;
	assign word.frame_end    = frame_end_q;
	assign word.last         = last_q;

endmodule

// File: rtl/core/led_matrix_frame_buffer_scanner.sv
// Top level of the LED matrix frame buffer scanner with its configuration registers.
//
// Commands arrive on the cmd channel (valid/ready): clear, set point, fill rectangle
// and render. A front end clips each draw to the grid and drops empty ones; a two-entry
// job queue decouples it from the store engine. A point or rectangle is applied to
// each store byte it touches by a read, then a masked write at the same store address;
// with the default parameters the whole store holds 64 bytes.
// Render emits 8*tiles_across*tiles_down words on the word channel, one per cycle
// when the receiver keeps ready high. The first word follows the queue and a store read
// into the output register. The store read for the next word is issued as each word
// enters the output register, so a stalled receiver simply holds the scan in place.
// frame_end marks the word for tile zero, last the final word of the run.
// The APB port holds tiles_across (address 0) and tiles_down (address 4); values
// outside their range are taken as the nearest legal value. Write them only while idle.
// Reset clears the queue, the output register and the per-byte valid flags, so the
// whole store reads as zero at once; both registers return to 1.
module led_matrix_frame_buffer_scanner #(
	parameter int MAX_TILES_ACROSS = 4,
	parameter int MAX_TILES_DOWN   = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	lmfb_cmd_if.sink                      cmd,
	lmfb_word_if.source                   word,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lmfb_pkg::PADDR_W-1:0]  paddr,
	input  logic [lmfb_pkg::PDATA_W-1:0]  pwdata,
	output logic [lmfb_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	localparam int CW  = $clog2(8*MAX_TILES_ACROSS);
	localparam int RW  = $clog2(8*MAX_TILES_DOWN);
	localparam int AAW = $clog2(MAX_TILES_ACROSS+1);
	localparam int DDW = $clog2(MAX_TILES_DOWN+1);

	logic [2:0]     across_q;
	logic [1:0]     down_q;
	logic [AAW-1:0] a_eff;
	logic [DDW-1:0] d_eff;

	// Register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			across_q <= 3'd1;
			down_q   <= 2'd1;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				lmfb_pkg::REG_ACROSS: across_q <= pwdata[2:0];
				lmfb_pkg::REG_DOWN:   down_q   <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	// Register read-back
	always_comb begin
		case (paddr[2])
			lmfb_pkg::REG_ACROSS: prdata = {29'd0, across_q};
			lmfb_pkg::REG_DOWN:   prdata = {30'd0, down_q};
			default:              prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	// Clamp layout to the legal range
	always_comb begin
		if (across_q == 3'd0) begin
			a_eff = AAW'(1);
		end else if (32'(across_q) > MAX_TILES_ACROSS) begin
			a_eff = AAW'(MAX_TILES_ACROSS);
		end else begin
			a_eff = AAW'(across_q);
		end
		if (down_q == 2'd0) begin
			d_eff = DDW'(1);
		end else if (32'(down_q) > MAX_TILES_DOWN) begin
			d_eff = DDW'(MAX_TILES_DOWN);
		end else begin
			d_eff = DDW'(down_q);
		end
	end

	lmfb_job_if #(.CW(CW), .RW(RW)) job_in ();
	lmfb_job_if #(.CW(CW), .RW(RW)) job_out ();

	lmfb_front #(
		.MAX_A (MAX_TILES_ACROSS),
		.MAX_D (MAX_TILES_DOWN)
	) u_front (
		.a_eff (a_eff),
		.d_eff (d_eff),
		.cmd   (cmd),
		.job   (job_in)
	);

	lmfb_queue #(
		.CW (CW),
		.RW (RW)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_job  (job_in),
		.out_job (job_out)
	);

	lmfb_back #(
		.MAX_A (MAX_TILES_ACROSS),
		.MAX_D (MAX_TILES_DOWN)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.a_eff  (a_eff),
		.d_eff  (d_eff),
		.job    (job_out),
		.word   (word)
	);

endmodule

// File: tb/sv/tb_led_matrix_frame_buffer_scanner.sv
// Self-checking testbench for the LED matrix frame buffer scanner: draw, clear and scan commands.
module tb_led_matrix_frame_buffer_scanner;

	localparam int MAX_ACROSS   = 4;
	localparam int MAX_DOWN     = 2;
	localparam int TILE_ROWS    = 8;
	localparam int ROW_REG_BASE = 9;
	localparam int STORE_BYTES  = TILE_ROWS * MAX_ACROSS * MAX_DOWN;
	localparam int DRAIN_CYCLES = 1000;
	localparam int STALL_CYCLES = 500;
	localparam int LIMIT_CYCLES = 2000000;

	typedef struct {
		logic        [1:0] kind;
		logic signed [7:0] pos_x;
		logic signed [7:0] pos_y;
		logic        [6:0] rect_width;
		logic        [6:0] rect_height;
		logic              pixel_on;
	} cmd_item_t;

	typedef struct {
		logic [3:0] row_register;
		logic [7:0] row_data;
		logic       frame_end;
		logic       last_word;
	} scan_word_t;

	logic                          clk;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [lmfb_pkg::PADDR_W-1:0]  paddr;
	logic [lmfb_pkg::PDATA_W-1:0]  pwdata;
	logic [lmfb_pkg::PDATA_W-1:0]  prdata;
	logic                          pready;

	lmfb_cmd_if  cmd_ch ();
	lmfb_word_if word_ch ();

	led_matrix_frame_buffer_scanner #(
		.MAX_TILES_ACROSS (MAX_ACROSS),
		.MAX_TILES_DOWN   (MAX_DOWN)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.word    (word_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow of the frame store and the layout registers
	logic [7:0] image [STORE_BYTES];
	logic [2:0] tiles_across_q;
	logic [1:0] tiles_down_q;

	cmd_item_t  pending_cmds [$];
	scan_word_t scan_words_due [$];
	cmd_item_t  cmd_held;

	int  n_queued;
	int  n_accepted;
	int  n_scans;
	int  n_words_checked;
	int  n_settings;
	int  errors;
	int  src_gap;
	int  snk_gap;
	bit  no_idle;
	bit  pressure_go;
	logic rx_hold;

	function automatic int eff_across();
		if (tiles_across_q == 0) return 1;
		if (tiles_across_q > MAX_ACROSS) return MAX_ACROSS;
		return int'(tiles_across_q);
	endfunction

	function automatic int eff_down();
		if (tiles_down_q == 0) return 1;
		if (tiles_down_q > MAX_DOWN) return MAX_DOWN;
		return int'(tiles_down_q);
	endfunction

	// Paint a clipped rectangle into the shadow store
	task automatic paint_area(input int x, input int y, input int w, input int h, input logic on);
		int a, xmax, ymax, x0, x1, y0, y1, idx;
		a    = eff_across();
		xmax = 8 * a;
		ymax = 8 * eff_down();
		x0   = (x < 1) ? 1 : x;
		y0   = (y < 1) ? 1 : y;
		x1   = x + w - 1;
		y1   = y + h - 1;
		if (x1 > xmax) x1 = xmax;
		if (y1 > ymax) y1 = ymax;
		for (int px = x0; px <= x1; px++)
			for (int py = y0; py <= y1; py++) begin
				idx = a * (py - 1) + (px - 1) / 8;
				if (idx < STORE_BYTES) image[idx][(px - 1) % 8] = on;
			end
	endtask

	// Apply one command to the shadow store; a scan queues its words
	task automatic update_image_and_scan(input cmd_item_t c);
		int a, n, t, idx;
		scan_word_t sw;
		case (c.kind)
			lmfb_pkg::KIND_CLEAR: begin
				for (int i = 0; i < STORE_BYTES; i++) image[i] = 8'h00;
			end
			lmfb_pkg::KIND_POINT: begin
				paint_area(int'(c.pos_x), int'(c.pos_y), 1, 1, c.pixel_on);
			end
			lmfb_pkg::KIND_FILL: begin
				paint_area(int'(c.pos_x), int'(c.pos_y), int'(c.rect_width),
					int'(c.rect_height), c.pixel_on);
			end
			default: begin
				a = eff_across();
				n = a * eff_down();
				n_scans++;
				for (int row = 1; row <= TILE_ROWS; row++)
					for (int k = 0; k < n; k++) begin
						t   = n - 1 - k;
						idx = (t % a) + (t / a) * 8 * a + (row - 1) * a;
						sw.row_register = 4'(ROW_REG_BASE - row);
						sw.row_data     = (idx < STORE_BYTES) ? image[idx] : 8'h00;
						sw.frame_end    = (t == 0);
						sw.last_word    = (row == TILE_ROWS) && (t == 0);
						scan_words_due.push_back(sw);
					end
			end
		endcase
	endtask

	task automatic queue_cmd(input logic [1:0] kind, input int x, input int y, input int w,
		input int h, input logic on);
		cmd_item_t c;
		c.kind        = kind;
		c.pos_x       = x[7:0];
		c.pos_y       = y[7:0];
		c.rect_width  = w[6:0];
		c.rect_height = h[6:0];
		c.pixel_on    = on;
		pending_cmds.push_back(c);
		n_queued++;
	endtask

	// Mostly in-grid draws with small extents, some raw values across the full fields
	task automatic queue_random(input int count);
		int pick, a, d, x, y, w, h;
		logic [1:0] kind;
		a = eff_across();
		d = eff_down();
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 5) kind = lmfb_pkg::KIND_CLEAR;
			else if (pick < 45) kind = lmfb_pkg::KIND_POINT;
			else if (pick < 80) kind = lmfb_pkg::KIND_FILL;
			else kind = lmfb_pkg::KIND_RENDER;
			if ($urandom_range(0, 6) == 0) x = $urandom;
			else x = $urandom_range(0, 8 * a + 3) - 1;
			if ($urandom_range(0, 6) == 0) y = $urandom;
			else y = $urandom_range(0, 8 * d + 3) - 1;
			pick = $urandom_range(0, 9);
			if (pick < 7) w = $urandom_range(0, 12);
			else if (pick < 9) w = $urandom_range(0, 64);
			else w = $urandom_range(0, 127);
			pick = $urandom_range(0, 9);
			if (pick < 7) h = $urandom_range(0, 12);
			else if (pick < 9) h = $urandom_range(0, 64);
			else h = $urandom_range(0, 127);
			queue_cmd(kind, x, y, w, h, $urandom_range(0, 1));
		end
	endtask

	task automatic wait_idle();
		while (n_accepted != n_queued || scan_words_due.size() != 0) @(posedge clk);
	endtask

	// Two-phase register write, shadow updated with it
	task automatic cfg_write(input logic reg_sel, input logic [lmfb_pkg::PDATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (reg_sel == lmfb_pkg::REG_ACROSS) tiles_across_q = value[2:0];
		else tiles_down_q = value[1:0];
	endtask

	// Let the block drain, then change the layout; upper data bits sometimes carry noise
	task automatic set_layout(input int across, input int down);
		logic [lmfb_pkg::PDATA_W-1:0] va, vd;
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		va = across;
		vd = down;
		if ($urandom_range(0, 1) == 1) va = va | ($urandom & ~32'h7);
		if ($urandom_range(0, 1) == 1) vd = vd | ($urandom & ~32'h3);
		cfg_write(lmfb_pkg::REG_ACROSS, va);
		cfg_write(lmfb_pkg::REG_DOWN, vd);
		n_settings++;
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Command driver: present queued items, idle in random bursts between transactions
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			src_gap = 0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				update_image_and_scan(cmd_held);
				n_accepted++;
			end
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (src_gap == 0 && !no_idle && $urandom_range(0, 7) == 0)
					src_gap = $urandom_range(1, 12);
				if (src_gap > 0) begin
					src_gap--;
					cmd_ch.valid <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					cmd_held = pending_cmds.pop_front();
					cmd_ch.kind        <= cmd_held.kind;
					cmd_ch.pos_x       <= cmd_held.pos_x;
					cmd_ch.pos_y       <= cmd_held.pos_y;
					cmd_ch.rect_width  <= cmd_held.rect_width;
					cmd_ch.rect_height <= cmd_held.rect_height;
					cmd_ch.pixel_on    <= cmd_held.pixel_on;
					cmd_ch.valid       <= 1'b1;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Word monitor: check each transaction against the oldest expected word
	always @(posedge clk or negedge arst_n) begin
		scan_word_t sw;
		if (!arst_n) begin
			word_ch.ready <= 1'b0;
			snk_gap = 0;
		end else begin
			if (word_ch.valid && word_ch.ready) begin
				if (scan_words_due.size() == 0) begin
					if (errors < 20)
						$display("%0t: unexpected word, expected none, actual reg %0d data %h fe %b last %b",
							$time, word_ch.row_register, word_ch.row_data,
							word_ch.frame_end, word_ch.last);
					errors++;
				end else begin
					sw = scan_words_due.pop_front();
					n_words_checked++;
					if (word_ch.row_register !== sw.row_register || word_ch.row_data !== sw.row_data ||
						word_ch.frame_end !== sw.frame_end || word_ch.last !== sw.last_word) begin
						if (errors < 20)
							$display("%0t: word mismatch, expected reg %0d data %h fe %b last %b, actual reg %0d data %h fe %b last %b",
								$time, sw.row_register, sw.row_data, sw.frame_end, sw.last_word,
								word_ch.row_register, word_ch.row_data, word_ch.frame_end,
								word_ch.last);
						errors++;
					end
				end
			end
			if (snk_gap > 0) snk_gap--;
			else if (!no_idle && $urandom_range(0, 15) == 0) snk_gap = $urandom_range(1, 12);
			word_ch.ready <= !(rx_hold || snk_gap > 0);
		end
	end

	// Long receiver hold-off so the command channel backs up
	initial begin
		rx_hold = 1'b0;
		wait (pressure_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (STALL_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// Run limit
	initial begin
		#(LIMIT_CYCLES * 12);
		$display("FAIL led_matrix_frame_buffer_scanner");
		$finish;
	end

	// Stimulus and end of run
	initial begin
		cmd_ch.valid       = 1'b0;
		cmd_ch.kind        = lmfb_pkg::KIND_CLEAR;
		cmd_ch.pos_x       = '0;
		cmd_ch.pos_y       = '0;
		cmd_ch.rect_width  = '0;
		cmd_ch.rect_height = '0;
		cmd_ch.pixel_on    = 1'b0;
		word_ch.ready      = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		no_idle            = 1'b0;
		pressure_go        = 1'b0;
		n_queued           = 0;
		n_accepted         = 0;
		n_scans            = 0;
		n_words_checked    = 0;
		n_settings         = 1;
		errors             = 0;
		tiles_across_q     = 3'd1;
		tiles_down_q       = 2'd1;
		for (int i = 0; i < STORE_BYTES; i++) image[i] = 8'h00;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single tile after reset: corners, off-grid points, clipping, empty fills
		queue_cmd(lmfb_pkg::KIND_RENDER, 0, 0, 0, 0, 1'b0);
		queue_cmd(lmfb_pkg::KIND_POINT, 1, 1, 0, 0, 1'b1);
		queue_cmd(lmfb_pkg::KIND_POINT, 8, 8, 127, 127, 1'b1);
		queue_cmd(lmfb_pkg::KIND_POINT, 0, 5, 0, 0, 1'b1);
		queue_cmd(lmfb_pkg::KIND_POINT, 9, 1, 0, 0, 1'b1);
		queue_cmd(lmfb_pkg::KIND_POINT, -128, 127, 0, 0, 1'b1);
		queue_cmd(lmfb_pkg::KIND_RENDER, 127, -128, 127, 127, 1'b1);
		queue_cmd(lmfb_pkg::KIND_FILL, -5, -5, 64, 64, 1'b1);
		queue_cmd(lmfb_pkg::KIND_FILL, 3, 3, 0, 5, 1'b0);
		queue_cmd(lmfb_pkg::KIND_FILL, 3, 3, 4, 0, 1'b0);
		queue_cmd(lmfb_pkg::KIND_FILL, 2, 2, 3, 3, 1'b0);
		queue_cmd(lmfb_pkg::KIND_RENDER, 0, 0, 0, 0, 1'b0);
		queue_cmd(lmfb_pkg::KIND_CLEAR, 127, 127, 127, 127, 1'b1);
		queue_cmd(lmfb_pkg::KIND_RENDER, 0, 0, 0, 0, 1'b0);
		queue_cmd(lmfb_pkg::KIND_POINT, 5, 6, 0, 0, 1'b1);

		// Largest layout: store kept across the change, far corner and oversized fills
		set_layout(MAX_ACROSS, MAX_DOWN);
		queue_cmd(lmfb_pkg::KIND_RENDER, 0, 0, 0, 0, 1'b0);
		queue_cmd(lmfb_pkg::KIND_POINT, 32, 16, 0, 0, 1'b1);
		queue_cmd(lmfb_pkg::KIND_POINT, 33, 1, 0, 0, 1'b1);
		queue_cmd(lmfb_pkg::KIND_POINT, 1, 17, 0, 0, 1'b1);
		queue_cmd(lmfb_pkg::KIND_FILL, 30, 14, 127, 127, 1'b1);
		queue_cmd(lmfb_pkg::KIND_FILL, 127, 127, 127, 127, 1'b1);
		queue_cmd(lmfb_pkg::KIND_FILL, -128, -128, 127, 127, 1'b1);
		queue_cmd(lmfb_pkg::KIND_FILL, 7, 3, 20, 9, 1'b0);
		queue_cmd(lmfb_pkg::KIND_RENDER, 0, 0, 0, 0, 1'b0);
		queue_random(50);

		// Zero registers fall back to one tile
		set_layout(0, 0);
		queue_cmd(lmfb_pkg::KIND_RENDER, 0, 0, 0, 0, 1'b0);
		queue_random(35);

		// Oversized registers clamp; hold the receiver off while scans pile up
		set_layout(7, 3);
		wait_idle();
		pressure_go = 1'b1;
		repeat (4) queue_cmd(lmfb_pkg::KIND_RENDER, 0, 0, 0, 0, 1'b0);
		queue_random(40);

		set_layout(2, 1);
		queue_random(40);
		set_layout(3, 2);
		queue_random(40);
		set_layout(1, 2);
		queue_random(40);

		// Final stretch at full rate
		set_layout(4, 1);
		wait_idle();
		no_idle = 1'b1;
		queue_random(50);
		queue_cmd(lmfb_pkg::KIND_RENDER, 0, 0, 0, 0, 1'b0);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (scan_words_due.size() != 0)
			$display("%0t: %0d expected words never arrived", $time, scan_words_due.size());
		$display("Covered %0d commands including %0d scans over %0d layouts, clamped values among them.",
			n_accepted, n_scans, n_settings);
		$display("Checked %0d scan words, with random idling and one long output stall.",
			n_words_checked);
		if (errors == 0 && scan_words_due.size() == 0) begin
			$display("PASS led_matrix_frame_buffer_scanner");
		end else begin
			$display("FAIL led_matrix_frame_buffer_scanner");
		end
		$finish;
	end

endmodule
